/* hw/rtl/ndsag_pkg.sv */
package ndsag_pkg;

  localparam int MAX_DIMS_DEF    = 4;
  localparam int EXTENT_BITS_DEF = 16;

  localparam int IDX_W  = 32;
  localparam int OFS_W  = 48;
  localparam int DATA_W = 64;
  localparam int CFG_W  = 64;
  localparam int STEP_W = $clog2(IDX_W);

  localparam int QUEUE_DEPTH = 2;
  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_RANK    = 3'd0;
  localparam reg_idx_t REG_ESIZE   = 3'd1;
  localparam reg_idx_t REG_START   = 3'd2;
  localparam reg_idx_t REG_EXTENTS = 3'd3;
  localparam reg_idx_t REG_STRIDES = 3'd4;

  typedef logic [1:0] esize_t;
  localparam esize_t ESIZE_1B = 2'd0;
  localparam esize_t ESIZE_2B = 2'd1;
  localparam esize_t ESIZE_4B = 2'd2;
  localparam esize_t ESIZE_8B = 2'd3;

  typedef struct packed {
    logic              first;
    logic [DATA_W-1:0] data;
  } item_t;

  function automatic logic [DATA_W-1:0] elem_mask(input esize_t code);
    logic [DATA_W-1:0] m;
    case (code)
      ESIZE_1B: m = DATA_W'(64'h0000_0000_0000_00FF);
      ESIZE_2B: m = DATA_W'(64'h0000_0000_0000_FFFF);
      ESIZE_4B: m = DATA_W'(64'h0000_0000_FFFF_FFFF);
      default:  m = '1;
    endcase
    return m;
  endfunction

endpackage

/* hw/rtl/ndsag_cfg.sv */
module ndsag_cfg #(
  parameter int MAX_DIMS    = ndsag_pkg::MAX_DIMS_DEF,
  parameter int EXTENT_BITS = ndsag_pkg::EXTENT_BITS_DEF,
  localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         cfg_we,
  input  ndsag_pkg::reg_idx_t                          cfg_index,
  input  logic [ndsag_pkg::CFG_W-1:0]                  cfg_data,
  output logic [DW-1:0]                                rank_last,
  output ndsag_pkg::esize_t                            elem_size_code,
  output logic [ndsag_pkg::IDX_W-1:0]                  start_index,
  output logic [MAX_DIMS-1:0][EXTENT_BITS-1:0]         ext_eff,
  output logic [MAX_DIMS-1:0][EXTENT_BITS-1:0]         strides,
  output logic [MAX_DIMS-1:0][ndsag_pkg::OFS_W-1:0]    stride_sx,
  output logic [MAX_DIMS-1:0][ndsag_pkg::OFS_W-1:0]    corr
);

  localparam int PADW = ndsag_pkg::CFG_W + MAX_DIMS * EXTENT_BITS;
  localparam int PW   = 2 * EXTENT_BITS + 1;

  logic [2:0]                  rank_in_use;
  logic [ndsag_pkg::CFG_W-1:0] extents_packed;
  logic [ndsag_pkg::CFG_W-1:0] strides_packed;
  logic [PADW-1:0]             ext_pad;
  logic [PADW-1:0]             str_pad;
  logic [3:0]                  rank_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      rank_in_use    <= 3'd1;
      elem_size_code <= ndsag_pkg::ESIZE_1B;
      start_index    <= '0;
      extents_packed <= '0;
      strides_packed <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ndsag_pkg::REG_RANK:    rank_in_use    <= cfg_data[2:0];
        ndsag_pkg::REG_ESIZE:   elem_size_code <= cfg_data[1:0];
        ndsag_pkg::REG_START:   start_index    <= cfg_data[ndsag_pkg::IDX_W-1:0];
        ndsag_pkg::REG_EXTENTS: extents_packed <= cfg_data;
        ndsag_pkg::REG_STRIDES: strides_packed <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (rank_in_use == 3'd0) begin
      rank_eff = 4'd1;
    end else if (int'(rank_in_use) > MAX_DIMS) begin
      rank_eff = 4'(MAX_DIMS);
    end else begin
      rank_eff = {1'b0, rank_in_use};
    end
    rank_last = DW'(rank_eff - 4'd1);
  end

  assign ext_pad = PADW'(extents_packed);
  assign str_pad = PADW'(strides_packed);

  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_dim
    logic [EXTENT_BITS-1:0] ext_raw;
    assign ext_raw      = ext_pad[d*EXTENT_BITS +: EXTENT_BITS];
    assign ext_eff[d]   = (ext_raw == '0) ? EXTENT_BITS'(1) : ext_raw;
    assign strides[d]   = str_pad[d*EXTENT_BITS +: EXTENT_BITS];
    assign stride_sx[d] = ndsag_pkg::OFS_W'(signed'(strides[d]));
  end

  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_corr
    if (d < MAX_DIMS - 1) begin : g_mul
      logic signed [PW-1:0] ep;
      assign ep = $signed({1'b0, ext_eff[d+1]}) * $signed(strides[d+1]);
      always_ff @(posedge clk) begin
        corr[d] <= stride_sx[d] - ndsag_pkg::OFS_W'(ep);
      end
    end else begin : g_none
      assign corr[d] = '0;
    end
  end

endmodule

/* hw/rtl/ndsag_queue.sv */
module ndsag_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ndsag_pkg::item_t wr_item,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output ndsag_pkg::item_t head
);

  ndsag_pkg::item_t               mem [ndsag_pkg::QUEUE_DEPTH];
  logic [ndsag_pkg::QAW-1:0]      wr_ptr;
  logic [ndsag_pkg::QAW-1:0]      rd_ptr;
  logic [ndsag_pkg::QCW-1:0]      count;
  logic                           do_push;
  logic                           do_pop;

  assign full       = (count == ndsag_pkg::QCW'(ndsag_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hw/rtl/ndsag_back.sv */
module ndsag_back #(
  parameter int MAX_DIMS    = ndsag_pkg::MAX_DIMS_DEF,
  parameter int EXTENT_BITS = ndsag_pkg::EXTENT_BITS_DEF,
  localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         head_valid,
  input  ndsag_pkg::item_t                             head,
  output logic                                         pop,
  input  logic [DW-1:0]                                rank_last,
  input  ndsag_pkg::esize_t                            elem_size_code,
  input  logic [ndsag_pkg::IDX_W-1:0]                  start_index,
  input  logic [MAX_DIMS-1:0][EXTENT_BITS-1:0]         ext_eff,
  input  logic [MAX_DIMS-1:0][EXTENT_BITS-1:0]         strides,
  input  logic [MAX_DIMS-1:0][ndsag_pkg::OFS_W-1:0]    stride_sx,
  input  logic [MAX_DIMS-1:0][ndsag_pkg::OFS_W-1:0]    corr,
  output logic                                         out_valid,
  input  logic                                         out_ready,
  output logic [ndsag_pkg::IDX_W-1:0]                  dest_offset,
  output logic [ndsag_pkg::DATA_W-1:0]                 out_data,
  output logic                                         offset_bad
);

  localparam int EB    = EXTENT_BITS;
  localparam int PW    = 2 * EB + 1;
  localparam int OFS_W = ndsag_pkg::OFS_W;
  localparam int IDX_W = ndsag_pkg::IDX_W;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_ACC  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t                       state;
  logic [MAX_DIMS-1:0][EB-1:0]  coord;
  logic [MAX_DIMS-1:0][EB-1:0]  coord_next;
  logic [OFS_W-1:0]             ofs;
  logic [OFS_W-1:0]             ofs_next;
  logic [IDX_W-1:0]             quo;
  logic [EB-1:0]                rem;
  logic [ndsag_pkg::STEP_W-1:0] step;
  logic [DW-1:0]                dim;
  logic signed [PW-1:0]         prod;
  logic [OFS_W-1:0]             acc;
  logic [OFS_W-1:0]             acc_next;
  logic [MAX_DIMS-1:0]          wrap;
  logic [EB:0]                  trial;
  logic                         fits;
  logic                         out_free;
  logic                         emit;

  assign out_free = !out_valid || out_ready;
  assign emit     = out_free && head_valid &&
                    ((state == ST_IDLE && !head.first) || state == ST_EMIT);
  assign pop      = emit;

  assign trial    = {rem, quo[IDX_W-1]};
  assign fits     = trial >= {1'b0, ext_eff[dim]};
  assign acc_next = acc + OFS_W'(prod);

  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_wrap
    assign wrap[d] = ((EB+1)'(coord[d]) + (EB+1)'(1)) >= {1'b0, ext_eff[d]};
  end

  always_comb begin
    logic carry;
    logic cin;
    carry      = 1'b0;
    coord_next = coord;
    ofs_next   = ofs + stride_sx[rank_last];
    for (int d = MAX_DIMS - 1; d >= 0; d--) begin
      if (d == int'(rank_last)) begin
        cin = 1'b1;
      end else if (d > int'(rank_last)) begin
        cin = 1'b0;
      end else begin
        cin = carry;
      end
      if (cin) begin
        coord_next[d] = wrap[d] ? '0 : EB'(coord[d] + 1'b1);
        if (d != int'(rank_last)) begin
          ofs_next = ofs_next + corr[d];
        end
      end
      carry = cin & wrap[d];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      coord     <= '0;
      ofs       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        coord     <= coord_next;
        ofs       <= ofs_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (head_valid && head.first) begin
            coord <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (step == ndsag_pkg::STEP_W'(IDX_W - 1)) begin
            coord[dim] <= fits ? EB'(trial - {1'b0, ext_eff[dim]}) : EB'(trial);
            state      <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_ACC;
        end
        ST_ACC: begin
          if (dim == '0) begin
            ofs   <= acc_next;
            state <= ST_EMIT;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_EMIT: begin
          if (emit) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        quo  <= start_index;
        rem  <= '0;
        step <= '0;
        dim  <= rank_last;
        acc  <= '0;
      end
      ST_DIV: begin
        rem  <= fits ? EB'(trial - {1'b0, ext_eff[dim]}) : EB'(trial);
        quo  <= {quo[IDX_W-2:0], fits};
        step <= step + 1'b1;
      end
      ST_MUL: begin
        prod <= $signed({1'b0, coord[dim]}) * $signed(strides[dim]);
      end
      ST_ACC: begin
        acc  <= acc_next;
        rem  <= '0;
        step <= '0;
        if (dim != '0) begin
          dim <= dim - 1'b1;
        end
      end
      default: ;
    endcase
    if (emit) begin
      dest_offset <= ofs[IDX_W-1:0];
      out_data    <= head.data & ndsag_pkg::elem_mask(elem_size_code);
      offset_bad  <= |ofs[OFS_W-1:IDX_W];
    end
  end

endmodule

/* hw/rtl/nd_strided_scatter_address_gen.sv */
// Scatter address generator for an N-dimensional transpose.
// Input channel (in_valid/in_ready): one source element per beat, in linear
// order; first marks the element at start_index and restarts the coordinates.
// Output channel (out_valid/out_ready): one beat per input element, in order,
// with the destination offset, the element masked to its size, and a flag for
// offsets outside the 32-bit range.
// Configuration: write cfg_data to register cfg_index while no beat is in
// flight; rank, element size, start index, packed extents and strides.
// Timing: an ordinary element passes through the queue and then the output
// register, and elements stream at one per cycle while the receiver is ready.
// An element marked first splits the start index with a bit-serial divider
// for each dimension, followed by a multiply and an accumulate step.
// A two-entry queue sits between the input and the address engine, and the
// output is registered: a stalled receiver holds the result, the engine waits
// before emitting the next, and in_ready drops once the queue fills.
// Reset: coordinates and offset clear, rank reads 1, other configuration registers 0.
module nd_strided_scatter_address_gen #(
  parameter int MAX_DIMS    = ndsag_pkg::MAX_DIMS_DEF,
  parameter int EXTENT_BITS = ndsag_pkg::EXTENT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  ndsag_pkg::reg_idx_t           cfg_index,
  input  logic [ndsag_pkg::CFG_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          first,
  input  logic [ndsag_pkg::DATA_W-1:0]  elem_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ndsag_pkg::IDX_W-1:0]   dest_offset,
  output logic [ndsag_pkg::DATA_W-1:0]  out_data,
  output logic                          offset_bad
);

  localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  logic [DW-1:0]                                rank_last;
  ndsag_pkg::esize_t                            elem_size_code;
  logic [ndsag_pkg::IDX_W-1:0]                  start_index;
  logic [MAX_DIMS-1:0][EXTENT_BITS-1:0]         ext_eff;
  logic [MAX_DIMS-1:0][EXTENT_BITS-1:0]         strides;
  logic [MAX_DIMS-1:0][ndsag_pkg::OFS_W-1:0]    stride_sx;
  logic [MAX_DIMS-1:0][ndsag_pkg::OFS_W-1:0]    corr;
  ndsag_pkg::item_t                             wr_item;
  ndsag_pkg::item_t                             head;
  logic                                         full;
  logic                                         head_valid;
  logic                                         pop;

  assign in_ready      = !full;
  assign wr_item.first = first;
  assign wr_item.data  = elem_data;

  ndsag_cfg #(
    .MAX_DIMS    (MAX_DIMS),
    .EXTENT_BITS (EXTENT_BITS)
  ) u_cfg (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .rank_last      (rank_last),
    .elem_size_code (elem_size_code),
    .start_index    (start_index),
    .ext_eff        (ext_eff),
    .strides        (strides),
    .stride_sx      (stride_sx),
    .corr           (corr)
  );

  ndsag_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (in_valid),
    .wr_item    (wr_item),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  ndsag_back #(
    .MAX_DIMS    (MAX_DIMS),
    .EXTENT_BITS (EXTENT_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop),
    .rank_last      (rank_last),
    .elem_size_code (elem_size_code),
    .start_index    (start_index),
    .ext_eff        (ext_eff),
    .strides        (strides),
    .stride_sx      (stride_sx),
    .corr           (corr),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .dest_offset    (dest_offset),
    .out_data       (out_data),
    .offset_bad     (offset_bad)
  );

endmodule
